FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Clocked on i_clk and held
// off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property sampled on every rising clock edge
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pvmd_pkg.sv
// ----------------------------------------------------------------------------
// pvmd_pkg
// Types and fixed widths of the peak / valley finder.
// ----------------------------------------------------------------------------
package pvmd_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int IDX_W      = 12;
    localparam int DIST_W     = 12;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 3;

    localparam logic [DIST_W-1:0] DIST_RESET = 12'd5;

    typedef enum logic [1:0] {
        KIND_MIN  = 2'd0,
        KIND_MAX  = 2'd1,
        KIND_NONE = 2'd2
    } t_kind;

    typedef struct packed {
        logic [IDX_W-1:0] peak_index;
        t_kind            kind;
        logic             end_res;
        logic             overflow;
    } t_res;

    typedef struct packed {
        t_res       e0;
        t_res       e1;
        logic [1:0] cnt;
    } t_pair;

    // Release of held peaks, lower index first
    function automatic t_pair release_pair(
        input logic             take_max,
        input logic             take_min,
        input logic             min_first,
        input logic [IDX_W-1:0] max_idx,
        input logic [IDX_W-1:0] min_idx
    );
        t_pair r;
        t_res  rmax;
        t_res  rmin;
        rmax = '{peak_index: max_idx, kind: KIND_MAX, end_res: 1'b0, overflow: 1'b0};
        rmin = '{peak_index: min_idx, kind: KIND_MIN, end_res: 1'b0, overflow: 1'b0};
        r.e0 = rmax;
        r.e1 = rmin;
        r.cnt = 2'd0;
        if (take_max && take_min) begin
            r.cnt = 2'd2;
            if (min_first) begin
                r.e0 = rmin;
                r.e1 = rmax;
            end
        end else if (take_max) begin
            r.cnt = 2'd1;
        end else if (take_min) begin
            r.e0 = rmin;
            r.cnt = 2'd1;
        end
        return r;
    endfunction

endpackage

FILE: sv/peak_valley_min_distance_unit.sv
// ----------------------------------------------------------------------------
// peak_valley_min_distance_unit
// Streaming peak / valley finder with a minimum spacing between kept peaks.
// ----------------------------------------------------------------------------
// A sample is taken into an input register, examined against the two previous
// samples and the held maximum and minimum, and its results (zero to three)
// are loaded into a three-entry result bank that drives the master stream. A
// sample that yields no result, or one, leaves room for the next sample in the
// following cycle, so while the master stream is not stalled the rate is one
// sample per cycle; after two or three results the next sample with results
// waits until the last is being taken, as the bank has a single read port.
// Peak indices count from the first sample of a run; samples beyond MAX_LEN
// are ignored and the run's last result then carries the overflow flag. The
// user must write min_peak_dist through the config channel only while the
// block is idle, which the block does not enforce; it resets to 5.
module peak_valley_min_distance_unit #(
    parameter int MAX_LEN = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config channel: min_peak_dist
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pvmd_pkg::DIST_W-1:0]       i_cfg_data,
    // sample stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pvmd_pkg::SAMPLE_W-1:0]     s_axis_tdata,   // [31:0] sample
    input  logic                              s_axis_tlast,   // last
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pvmd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [11:0] peak_index
    output logic [pvmd_pkg::OUT_USER_W-1:0]   m_axis_tuser,   // [1:0] kind, [2] overflow
    output logic                              m_axis_tlast    // end_res
);
    import pvmd_pkg::*;

    localparam int IW   = $clog2(MAX_LEN);
    localparam int CNTW = $clog2(MAX_LEN + 1);
    localparam int EW   = (IW > DIST_W) ? IW : DIST_W;

    // config
    logic [DIST_W-1:0]          r_min_dist;

    // input register
    logic                       r_in_valid;
    logic signed [SAMPLE_W-1:0] r_in_sample;
    logic                       r_in_last;

    // sequence state
    logic signed [SAMPLE_W-1:0] r_prior;
    logic signed [SAMPLE_W-1:0] r_older;
    logic [CNTW-1:0]            r_count;
    logic                       r_hmax_v;
    logic [IW-1:0]              r_hmax_idx;
    logic signed [SAMPLE_W-1:0] r_hmax_val;
    logic                       r_hmin_v;
    logic [IW-1:0]              r_hmin_idx;
    logic signed [SAMPLE_W-1:0] r_hmin_val;
    logic                       r_len_exc;

    // result bank
    t_res                       r_res [3];
    logic [1:0]                 r_res_cnt;

    // next values
    logic                       n_hmax_v;
    logic [IW-1:0]              n_hmax_idx;
    logic                       n_hmin_v;
    logic [IW-1:0]              n_hmin_idx;

    logic                       in_range;
    logic                       active;
    logic [IW-1:0]              pos;
    logic [EW-1:0]              dist_ext;
    logic [EW-1:0]              gap_max;
    logic [EW-1:0]              gap_min;
    logic                       conf_max;
    logic                       conf_min;
    logic                       is_max;
    logic                       is_min;
    logic                       hv_max;
    logic                       hv_min;
    logic                       upd_max;
    logic                       upd_min;
    logic [EW-1:0]              hmax_ext;
    logic [EW-1:0]              hmin_ext;
    logic [EW-1:0]              nmax_ext;
    logic [EW-1:0]              nmin_ext;
    t_pair                      list_a;
    t_pair                      list_b;
    t_res                       slot [3];
    logic [1:0]                 tot;
    logic                       overflow;
    logic                       bank_free;
    logic                       pop;
    logic                       proc_fire;
    logic                       load;

    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------- examine
    always_comb begin
        in_range = (r_count < CNTW'(MAX_LEN));
        active   = in_range && (r_count >= CNTW'(2));
        pos      = IW'(r_count - CNTW'(1));
        dist_ext = EW'(r_min_dist);
        gap_max  = EW'(IW'(pos - r_hmax_idx));
        gap_min  = EW'(IW'(pos - r_hmin_idx));

        conf_max = active && r_hmax_v && (gap_max >= dist_ext);
        conf_min = active && r_hmin_v && (gap_min >= dist_ext);

        is_max = active && ((r_prior > r_older && r_prior >= r_in_sample) ||
                            (r_prior >= r_older && r_prior > r_in_sample));
        is_min = active && ((r_prior < r_older && r_prior <= r_in_sample) ||
                            (r_prior <= r_older && r_prior < r_in_sample));

        hv_max  = r_hmax_v && !conf_max;
        hv_min  = r_hmin_v && !conf_min;
        upd_max = is_max && (!hv_max || r_prior > r_hmax_val);
        upd_min = is_min && (!hv_min || r_prior < r_hmin_val);

        n_hmax_v   = hv_max || upd_max;
        n_hmax_idx = upd_max ? pos : r_hmax_idx;
        n_hmin_v   = hv_min || upd_min;
        n_hmin_idx = upd_min ? pos : r_hmin_idx;

        hmax_ext = EW'(r_hmax_idx);
        hmin_ext = EW'(r_hmin_idx);
        nmax_ext = EW'(n_hmax_idx);
        nmin_ext = EW'(n_hmin_idx);

        list_a = release_pair(conf_max, conf_min, r_hmin_idx < r_hmax_idx,
                              hmax_ext[IDX_W-1:0], hmin_ext[IDX_W-1:0]);
        list_b = release_pair(r_in_last && n_hmax_v, r_in_last && n_hmin_v,
                              n_hmin_idx < n_hmax_idx,
                              nmax_ext[IDX_W-1:0], nmin_ext[IDX_W-1:0]);

        // concatenate both releases; together they never exceed three
        slot[0] = (list_a.cnt != 2'd0) ? list_a.e0 : list_b.e0;
        slot[1] = (list_a.cnt == 2'd2) ? list_a.e1 :
                  ((list_a.cnt == 2'd1) ? list_b.e0 : list_b.e1);
        slot[2] = (list_a.cnt == 2'd2) ? list_b.e0 : list_b.e1;
        tot     = list_a.cnt + list_b.cnt;

        overflow = r_len_exc || !in_range;

        // end of run with nothing to report: emit the end marker
        if (r_in_last && tot == 2'd0) begin
            slot[0] = '{peak_index: '0, kind: KIND_NONE, end_res: 1'b0, overflow: 1'b0};
            tot     = 2'd1;
        end

        for (int j = 0; j < 3; j++) begin
            if (r_in_last && tot == 2'(j + 1)) begin
                slot[j].end_res  = 1'b1;
                slot[j].overflow = overflow;
            end
        end
    end

    // ---------------------------------------------------------------- handshake
    assign pop       = (r_res_cnt != 2'd0) && m_axis_tready;
    assign bank_free = (r_res_cnt == 2'd0) || (r_res_cnt == 2'd1 && m_axis_tready);
    assign proc_fire = r_in_valid && (tot == 2'd0 || bank_free);
    assign load      = proc_fire && (tot != 2'd0);

    assign s_axis_tready = !r_in_valid || proc_fire;

    assign m_axis_tvalid = (r_res_cnt != 2'd0);
    assign m_axis_tdata  = OUT_DATA_W'(r_res[0].peak_index);
    assign m_axis_tuser  = {r_res[0].overflow, r_res[0].kind};
    assign m_axis_tlast  = r_res[0].end_res;

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= DIST_RESET;
            r_in_valid <= 1'b0;
            r_count    <= '0;
            r_hmax_v   <= 1'b0;
            r_hmin_v   <= 1'b0;
            r_len_exc  <= 1'b0;
            r_res_cnt  <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                r_min_dist <= i_cfg_data;
            end

            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (proc_fire) begin
                r_in_valid <= 1'b0;
            end

            if (proc_fire) begin
                if (r_in_last) begin
                    // run ends: clear the count, held-peak flags and overflow state
                    r_count   <= '0;
                    r_hmax_v  <= 1'b0;
                    r_hmin_v  <= 1'b0;
                    r_len_exc <= 1'b0;
                end else begin
                    if (in_range) begin
                        r_count <= r_count + CNTW'(1);
                    end
                    r_hmax_v  <= n_hmax_v;
                    r_hmin_v  <= n_hmin_v;
                    r_len_exc <= overflow;
                end
            end

            if (load) begin
                r_res_cnt <= tot;
            end else if (pop) begin
                r_res_cnt <= r_res_cnt - 2'd1;
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_sample <= s_axis_tdata;
            r_in_last   <= s_axis_tlast;
        end

        if (proc_fire && in_range) begin
            r_older    <= r_prior;
            r_prior    <= r_in_sample;
            r_hmax_idx <= n_hmax_idx;
            r_hmin_idx <= n_hmin_idx;
            if (upd_max) begin
                r_hmax_val <= r_prior;
            end
            if (upd_min) begin
                r_hmin_val <= r_prior;
            end
        end

        if (load) begin
            r_res[0] <= slot[0];
            r_res[1] <= slot[1];
            r_res[2] <= slot[2];
        end else if (pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    // ---------------------------------------------------------------- checks
`include "assert_macros.svh"

    `ASSERT_IMPL(a_none_is_end, m_axis_tvalid && m_axis_tuser[1:0] == KIND_NONE, m_axis_tlast, "end marker without tlast")
    `ASSERT_IMPL(a_ovf_on_end, m_axis_tvalid && m_axis_tuser[2], m_axis_tlast, "overflow flag on a result that is not the last")
    `ASSERT_IMPL(a_load_empty, load, r_res_cnt == 2'd0 || (r_res_cnt == 2'd1 && pop), "result bank overwritten")
    `ASSERT_NEXT(a_run_clear, proc_fire && r_in_last, r_count == '0 && !r_hmax_v && !r_hmin_v && !r_len_exc, "state kept past end of run")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the peak / valley finder. It drives sample runs
// into the block, predicts the confirmed peaks of each run and checks every
// result request in order. It starts with a directed table: extremes, ties,
// zero and maximum spacing. Random runs of mixed shapes follow under several
// idling patterns, with one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import pvmd_pkg::*;

    localparam int SEQ_DEPTH     = 4096;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 36;
    localparam int NUM_ROWS      = 30;

    typedef enum logic {
        ROW_SAMPLE = 1'b0,
        ROW_CFG    = 1'b1
    } t_row_op;

    typedef struct packed {
        t_row_op     op;
        logic [31:0] val;     // sample, or spacing for a config row
        logic        lst;
        logic        typed;   // use the result written below
        t_res        want;
    } t_stim_row;

    localparam t_res NO_RES  = '{peak_index: 12'd0, kind: KIND_MIN, end_res: 1'b0,
                                 overflow: 1'b0};
    localparam t_res END_NONE = '{peak_index: 12'd0, kind: KIND_NONE, end_res: 1'b1,
                                  overflow: 1'b0};
    localparam t_res END_MAX1 = '{peak_index: 12'd1, kind: KIND_MAX, end_res: 1'b1,
                                  overflow: 1'b0};

    localparam t_stim_row STIM_TAB [NUM_ROWS] = '{
        // single sample run, nothing to find
        '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 1'b1, END_NONE},
        // full-scale spike
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 1'b1, END_MAX1},
        // flat run
        '{ROW_SAMPLE, 32'd5, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd5, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd5, 1'b1, 1'b1, END_NONE},
        // zig-zag inside the default spacing
        '{ROW_SAMPLE, 32'd0, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd10, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd0, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd10, 1'b1, 1'b0, NO_RES},
        // zero spacing: every peak confirmed one sample later
        '{ROW_CFG, 32'd0, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd3, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'hFFFF_FFF9, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd3, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'hFFFF_FFF9, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd3, 1'b1, 1'b0, NO_RES},
        // widest spacing: replace by a higher peak, drop a lower one
        '{ROW_CFG, 32'd4095, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd1, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd100, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd1, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd200, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd1, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd50, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd1, 1'b1, 1'b0, NO_RES},
        // plateau top, strict on one side only
        '{ROW_SAMPLE, 32'd0, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd5, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd5, 1'b0, 1'b0, NO_RES},
        '{ROW_SAMPLE, 32'd0, 1'b1, 1'b0, NO_RES},
        '{ROW_CFG, 32'd5, 1'b0, 1'b0, NO_RES}
    };

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [DIST_W-1:0]       i_cfg_data    = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [SAMPLE_W-1:0]     s_axis_tdata  = '0;   // [31:0] sample
    logic                    s_axis_tlast  = 1'b0; // last
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;         // [11:0] peak_index
    logic [OUT_USER_W-1:0]   m_axis_tuser;         // [1:0] kind, [2] overflow
    logic                    m_axis_tlast;         // end_res

    peak_valley_min_distance_unit #(
        .MAX_LEN (SEQ_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Peak tracker state
    logic [DIST_W-1:0]    pk_dist     = DIST_RESET;
    logic signed [31:0]   pk_prior    = '0;
    logic signed [31:0]   pk_older    = '0;
    int unsigned          pk_count    = 0;
    logic                 pk_max_held = 1'b0;
    logic [IDX_W-1:0]     pk_max_idx  = '0;
    logic signed [31:0]   pk_max_val  = '0;
    logic                 pk_min_held = 1'b0;
    logic [IDX_W-1:0]     pk_min_idx  = '0;
    logic signed [31:0]   pk_min_val  = '0;
    logic                 pk_overflow = 1'b0;

    t_res pending_peaks [$];
    t_res new_peaks [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    int hold_left      = 0;

    int errors     = 0;
    int n_samples  = 0;
    int n_runs     = 0;
    int n_results  = 0;
    int quiet      = 0;

    task automatic emit_held(input logic take_max, input logic take_min);
        t_res rmax;
        t_res rmin;
        rmax = '{peak_index: pk_max_idx, kind: KIND_MAX, end_res: 1'b0, overflow: 1'b0};
        rmin = '{peak_index: pk_min_idx, kind: KIND_MIN, end_res: 1'b0, overflow: 1'b0};
        if (take_max && take_min) begin
            if (pk_min_idx < pk_max_idx) begin
                new_peaks.push_back(rmin);
                new_peaks.push_back(rmax);
            end else begin
                new_peaks.push_back(rmax);
                new_peaks.push_back(rmin);
            end
        end else if (take_max) begin
            new_peaks.push_back(rmax);
        end else if (take_min) begin
            new_peaks.push_back(rmin);
        end
        if (take_max) pk_max_held = 1'b0;
        if (take_min) pk_min_held = 1'b0;
    endtask

    // Advance the tracker by one sample and collect the peaks it confirms
    task automatic find_peaks(input logic signed [31:0] s, input logic lst);
        int unsigned        p;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               conf_max;
        logic               conf_min;
        logic               is_max;
        logic               is_min;
        new_peaks.delete();
        if (pk_count < SEQ_DEPTH) begin
            if (pk_count >= 2) begin
                p = pk_count - 1;
                a = pk_older;
                b = pk_prior;
                conf_max = pk_max_held && ((p - pk_max_idx) >= pk_dist);
                conf_min = pk_min_held && ((p - pk_min_idx) >= pk_dist);
                is_max = (b > a && b >= s) || (b >= a && b > s);
                is_min = (b < a && b <= s) || (b <= a && b < s);
                emit_held(conf_max, conf_min);
                if (is_max && (!pk_max_held || b > pk_max_val)) begin
                    pk_max_held = 1'b1;
                    pk_max_idx  = IDX_W'(p);
                    pk_max_val  = b;
                end
                if (is_min && (!pk_min_held || b < pk_min_val)) begin
                    pk_min_held = 1'b1;
                    pk_min_idx  = IDX_W'(p);
                    pk_min_val  = b;
                end
            end
            pk_older = pk_prior;
            pk_prior = s;
            pk_count = pk_count + 1;
        end else begin
            pk_overflow = 1'b1;
        end
        if (lst) begin
            emit_held(pk_max_held, pk_min_held);
            if (new_peaks.size() == 0) new_peaks.push_back(END_NONE);
            new_peaks[$].end_res  = 1'b1;
            new_peaks[$].overflow = pk_overflow;
            // start a fresh run, spacing stays
            pk_prior    = '0;
            pk_older    = '0;
            pk_count    = 0;
            pk_max_held = 1'b0;
            pk_max_idx  = '0;
            pk_max_val  = '0;
            pk_min_held = 1'b0;
            pk_min_idx  = '0;
            pk_min_val  = '0;
            pk_overflow = 1'b0;
        end
    endtask

    // Offer one sample, then record what it should produce
    task automatic take_sample(input logic [31:0] smp, input logic lst,
                               input logic typed, input t_res want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        n_samples++;
        if (lst) n_runs++;
        find_peaks(smp, lst);
        if (typed) begin
            pending_peaks.push_back(want);
        end else begin
            foreach (new_peaks[k]) pending_peaks.push_back(new_peaks[k]);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_peaks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_spacing(input logic [DIST_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pk_dist = v;
    endtask

    task automatic send_run(input int len, input int shape);
        logic [31:0] v;
        v = $urandom;
        for (int i = 0; i < len; i++) begin
            case (shape)
                0: v = $urandom;
                1: v = v + 32'($urandom_range(0, 6)) - 32'd3;
                2: v = 32'($urandom_range(0, 4)) - 32'd2;
                default: begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7FFF_FFFF;
                        2: v = 32'h0000_0000;
                        default: v = 32'hFFFF_FFFF;
                    endcase
                end
            endcase
            take_sample(v, i == len - 1, 1'b0, NO_RES);
        end
    endtask

    task automatic note_mismatch(input string msg);
        errors++;
        if (errors <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Result receiver, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        if ((hold_req && !hold_done) || hold_left != 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_peaks.size() == 0) begin
                note_mismatch($sformatf(
                    "unexpected result idx %0d kind %0d last %0b user %0h",
                    m_axis_tdata, m_axis_tuser[1:0], m_axis_tlast, m_axis_tuser));
            end else begin
                want = pending_peaks.pop_front();
                if (m_axis_tdata != OUT_DATA_W'(want.peak_index) ||
                    m_axis_tuser[1:0] != want.kind ||
                    m_axis_tuser[2] != want.overflow ||
                    m_axis_tlast != want.end_res)
                    note_mismatch($sformatf(
                        {"exp idx %0d kind %0d end %0b ovf %0b, ",
                         "got idx %0d kind %0d end %0b ovf %0b"},
                        want.peak_index, want.kind, want.end_res, want.overflow,
                        m_axis_tdata, m_axis_tuser[1:0], m_axis_tlast, m_axis_tuser[2]));
            end
        end
    end

    // Watchdog on cycles without any accepted request
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", quiet);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int dist_plan [8];
        int count;
        int len;
        int pick;
        dist_plan = '{2, 0, 4095, 1, 3, 0, 7, 0};
        dist_plan[5] = $urandom_range(0, 4095);
        dist_plan[7] = $urandom_range(0, 12);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 13;
        recv_stall_pct = 13;
        foreach (STIM_TAB[r]) begin
            if (STIM_TAB[r].op == ROW_CFG)
                write_spacing(STIM_TAB[r].val[DIST_W-1:0]);
            else
                take_sample(STIM_TAB[r].val, STIM_TAB[r].lst, STIM_TAB[r].typed,
                            STIM_TAB[r].want);
        end

        for (int ph = 0; ph < 8; ph++) begin
            write_spacing(dist_plan[ph][DIST_W-1:0]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            // hold the output off while samples keep coming
            if (ph == 0) hold_req <= 1'b1;
            count = 0;
            while (count < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)     len = $urandom_range(1, 2);
                else if (pick < 8) len = $urandom_range(3, 14);
                else               len = $urandom_range(15, 40);
                send_run(len, $urandom_range(0, 3));
                count += len;
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (pending_peaks.size() != 0)
            note_mismatch($sformatf("%0d expected results never arrived",
                                    pending_peaks.size()));

        $display("Run covered %0d samples in %0d runs, %0d results checked, %0d mismatches.",
                 n_samples, n_runs, n_results, errors);
        $display("Spacing 0 to 4095, four idling patterns and a long output hold-off.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: peak_valley_min_distance_unit.f
+incdir+sv
sv/pvmd_pkg.sv
sv/peak_valley_min_distance_unit.sv
verif/testbench.sv
